// ----- rtl/sd_card_spi_mode_target_macros.svh -----
// Assertion helpers for the SD SPI target.
`ifndef SD_CARD_SPI_MODE_TARGET_MACROS_SVH
`define SD_CARD_SPI_MODE_TARGET_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDSPI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDSPI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sdspi_pkg.sv -----
package sdspi_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned FRAME_BYTES = 515;

  localparam logic [7:0] BYTE_FF       = 8'hFF;
  localparam logic [7:0] TOKEN_SINGLE  = 8'hFE;
  localparam logic [7:0] TOKEN_MULTI   = 8'hFC;
  localparam logic [7:0] DATA_ACCEPTED = 8'hE5;
  localparam logic [7:0] R1_PARAM_ERR  = 8'h40;
  localparam logic [7:0] R1_ILLEGAL    = 8'h04;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
  localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
  localparam logic [5:0] CMD_STOP_TRAN    = 6'd12;
  localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;

  typedef enum logic [1:0] {
    WM_OFF,
    WM_SINGLE,
    WM_MULTI
  } wmode_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_POP,
    ST_WSKIP,
    ST_WDATA,
    ST_WCRC,
    ST_WEND,
    ST_MR,
    ST_LOOP,
    ST_SKIP,
    ST_CAP,
    ST_EXEC,
    ST_R8,
    ST_STOP,
    ST_GAP,
    ST_BTOK,
    ST_BRD,
    ST_BPUSH,
    ST_BCRC
  } state_e;

  typedef enum logic [3:0] {
    PB_R1,
    PB_R1_LEN,
    PB_R1_ILL,
    PB_00,
    PB_01,
    PB_FF,
    PB_FE,
    PB_E5,
    PB_ARG,
    PB_IMG
  } push_sel_e;

  typedef struct packed {
    logic      accept;
    logic      pwr_ff;
    logic      cmd_push;
    logic      cmd_pop;
    logic      resp_pop;
    logic      resp_push;
    push_sel_e push_sel;
    logic      resp_clear;
    logic      cap_first;
    logic      cap_arg;
    logic      img_rd;
    logic      img_wr;
    logic      clr_step;
    logic      pos_zero;
    logic      pos_load;
    logic      idle_set;
    logic      idle_clr;
    logic      multi_set;
    logic      multi_clr;
    logic      wmode_set;
    wmode_e    wmode_val;
    logic      wmode_clr;
  } ctrl_t;

  typedef struct packed {
    logic       cmd_empty;
    logic       cmd_ge6;
    logic       cmd_ge_frame;
    logic       cmd_ok;
    logic [7:0] cmd_head;
    logic       resp_empty;
    logic       resp_ok;
    logic       resp_head_ff;
    wmode_e     wmode;
    logic       multi;
    logic [5:0] idx;
    logic       clr_done;
    logic       mosi_hi;
    logic       out_free;
  } stat_t;

endpackage

// ----- rtl/sd_card_spi_mode_target.sv -----
// SD card in SPI mode, card side. Each input transfer is one full-duplex
// SPI byte: mosi_byte_i from the host and card_powered_i. Each one gives
// exactly one output transfer on miso_byte_o, in order.
// With power off the output is 0xFF and nothing else changes. Otherwise
// the byte out is the head of the response queue (0xFF when empty), and
// the byte in feeds the command queue, which is parsed into 6-byte frames.
// An unpowered byte shows its result in the cycle after acceptance; a
// powered byte passes through the push and pop states, waiting there for
// a valid response queue read, before its result is registered. Input is
// stalled until the item's work is done: parsing each received frame and,
// when a 512-byte block is moved, the registered reads for each byte.
// Reset clears the queues and all flags, then sweeps the card image to
// 0xFF, during which no byte is accepted.
// A stalled result stays in the output register; the next byte may be
// accepted once that register is free or being taken in the same cycle.
`include "sd_card_spi_mode_target_macros.svh"

module sd_card_spi_mode_target #(
  parameter int unsigned RESPONSE_DEPTH  = 1024,
  parameter int unsigned COMMAND_DEPTH   = 1024,
  parameter int unsigned READ_GAP_BYTES  = 4,
  parameter int unsigned STOP_BUSY_BYTES = 8,
  parameter int unsigned CARD_ADDR_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] mosi_byte_i,
  input  logic       card_powered_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] miso_byte_o
);
  import sdspi_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  out_held;
  logic  out_ff;
  logic  unpw_acc;
  logic  pw_acc;

  sdspi_ctrl #(
    .READ_GAP_BYTES (READ_GAP_BYTES),
    .STOP_BUSY_BYTES(STOP_BUSY_BYTES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .card_powered_i(card_powered_i),
    .stat_i        (stat),
    .in_stall_o    (in_stall_o),
    .ctrl_o        (ctrl)
  );

  sdspi_dp #(
    .RESPONSE_DEPTH(RESPONSE_DEPTH),
    .COMMAND_DEPTH (COMMAND_DEPTH),
    .CARD_ADDR_BITS(CARD_ADDR_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .mosi_byte_i(mosi_byte_i),
    .out_stall_i(out_stall_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .miso_byte_o(miso_byte_o)
  );

  assign out_held = out_valid_o && out_stall_i;
  assign out_ff   = out_valid_o && (miso_byte_o == BYTE_FF);
  assign unpw_acc = in_valid_i && !in_stall_o && !card_powered_i;
  assign pw_acc   = in_valid_i && !in_stall_o && card_powered_i;

  `SDSPI_ASSERT_NOW(a_held_blocks_input, out_held, in_stall_o, "input taken over held result")
  `SDSPI_ASSERT_NEXT(a_unpowered_ff, unpw_acc, out_ff, "unpowered byte not 0xFF")
  `SDSPI_ASSERT_NEXT(a_busy_after_powered, pw_acc, in_stall_o, "powered byte did not hold input")

endmodule

// ----- rtl/sdspi_dp.sv -----
module sdspi_dp #(
  parameter int unsigned RESPONSE_DEPTH = 1024,
  parameter int unsigned COMMAND_DEPTH  = 1024,
  parameter int unsigned CARD_ADDR_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdspi_pkg::ctrl_t  ctrl_i,
  input  logic [7:0]        mosi_byte_i,
  input  logic              out_stall_i,
  output sdspi_pkg::stat_t  stat_o,
  output logic              out_valid_o,
  output logic [7:0]        miso_byte_o
);
  import sdspi_pkg::*;

  localparam int unsigned RPW = $clog2(RESPONSE_DEPTH);
  localparam int unsigned RCW = $clog2(RESPONSE_DEPTH + 1);
  localparam int unsigned CPW = $clog2(COMMAND_DEPTH);
  localparam int unsigned CCW = $clog2(COMMAND_DEPTH + 1);
  localparam int unsigned POS_W = (CARD_ADDR_BITS + 1 > 32) ? CARD_ADDR_BITS + 1 : 32;
  localparam longint unsigned CARD_SIZE = 64'd1 << CARD_ADDR_BITS;

  // Response queue
  logic [7:0]     resp_mem [RESPONSE_DEPTH];
  logic [RPW-1:0] rhead_q, rhead_d, rtail_q, rtail_d, rrd_addr_q;
  logic [RCW-1:0] rcount_q, rcount_d;
  logic           rhit_q;
  logic [7:0]     rdata_q;
  logic           rpush_ok, rpop_ok, rempty;
  logic [7:0]     push_byte;

  // Command queue
  logic [7:0]     cmd_mem [COMMAND_DEPTH];
  logic [CPW-1:0] chead_q, chead_d, ctail_q, ctail_d, crd_addr_q;
  logic [CCW-1:0] ccount_q, ccount_d;
  logic           chit_q;
  logic [7:0]     cdata_q;
  logic           cpush_ok, cpop_ok;

  // Card image
  logic [7:0]                img_mem [CARD_SIZE];
  logic [7:0]                img_rdata_q;
  logic [POS_W-1:0]          pos_q, pos_d;
  logic                      inr, inr_q;
  logic                      img_we;
  logic [7:0]                img_wdata;

  logic [7:0]  mosi_q;
  logic [5:0]  idx_q;
  logic [31:0] arg_q;
  logic        idle_q, multi_q;
  wmode_e      wmode_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;

  assign rempty   = (rcount_q == '0);
  assign rpush_ok = ctrl_i.resp_push && (rcount_q != RCW'(RESPONSE_DEPTH));
  assign rpop_ok  = ctrl_i.resp_pop && !rempty;
  assign cpush_ok = ctrl_i.cmd_push && (ccount_q != CCW'(COMMAND_DEPTH));
  assign cpop_ok  = ctrl_i.cmd_pop && (ccount_q != '0);
  assign inr      = (pos_q[POS_W-1:CARD_ADDR_BITS] == '0);

  always_comb begin
    case (ctrl_i.push_sel)
      PB_R1:     push_byte = {7'd0, idle_q};
      PB_R1_LEN: push_byte = ((arg_q != 32'(BLOCK_BYTES)) ? R1_PARAM_ERR : 8'h00) |
                             {7'd0, idle_q};
      PB_R1_ILL: push_byte = R1_ILLEGAL | {7'd0, idle_q};
      PB_00:     push_byte = 8'h00;
      PB_01:     push_byte = 8'h01;
      PB_FE:     push_byte = TOKEN_SINGLE;
      PB_E5:     push_byte = DATA_ACCEPTED;
      PB_ARG:    push_byte = arg_q[7:0];
      PB_IMG:    push_byte = inr_q ? img_rdata_q : BYTE_FF;
      default:   push_byte = BYTE_FF;
    endcase
  end

  always_comb begin
    rhead_d  = rhead_q;
    rtail_d  = rtail_q;
    rcount_d = rcount_q;
    if (ctrl_i.resp_clear) begin
      rtail_d  = rhead_q;
      rcount_d = '0;
    end else begin
      if (rpush_ok) begin
        rtail_d = (rtail_q == RPW'(RESPONSE_DEPTH - 1)) ? '0 : rtail_q + 1'b1;
      end
      if (rpop_ok) begin
        rhead_d = (rhead_q == RPW'(RESPONSE_DEPTH - 1)) ? '0 : rhead_q + 1'b1;
      end
      rcount_d = rcount_q + RCW'(rpush_ok) - RCW'(rpop_ok);
    end
  end

  always_comb begin
    chead_d = chead_q;
    ctail_d = ctail_q;
    if (cpush_ok) begin
      ctail_d = (ctail_q == CPW'(COMMAND_DEPTH - 1)) ? '0 : ctail_q + 1'b1;
    end
    if (cpop_ok) begin
      chead_d = (chead_q == CPW'(COMMAND_DEPTH - 1)) ? '0 : chead_q + 1'b1;
    end
    ccount_d = ccount_q + CCW'(cpush_ok) - CCW'(cpop_ok);
  end

  always_comb begin
    pos_d = pos_q;
    if (ctrl_i.pos_zero) begin
      pos_d = '0;
    end else if (ctrl_i.pos_load) begin
      pos_d = POS_W'(arg_q);
    end else if (ctrl_i.clr_step || ((ctrl_i.img_rd || ctrl_i.img_wr) && inr)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  assign img_we    = ctrl_i.clr_step || (ctrl_i.img_wr && inr);
  assign img_wdata = ctrl_i.clr_step ? BYTE_FF : cdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhead_q     <= '0;
      rtail_q     <= '0;
      rcount_q    <= '0;
      rrd_addr_q  <= '0;
      rhit_q      <= 1'b1;
      chead_q     <= '0;
      ctail_q     <= '0;
      ccount_q    <= '0;
      crd_addr_q  <= '0;
      chit_q      <= 1'b1;
      pos_q       <= '0;
      idle_q      <= 1'b0;
      multi_q     <= 1'b0;
      wmode_q     <= WM_OFF;
      out_valid_q <= 1'b0;
    end else begin
      rhead_q    <= rhead_d;
      rtail_q    <= rtail_d;
      rcount_q   <= rcount_d;
      rrd_addr_q <= rhead_q;
      rhit_q     <= rpush_ok && (rtail_q == rhead_q);
      chead_q    <= chead_d;
      ctail_q    <= ctail_d;
      ccount_q   <= ccount_d;
      crd_addr_q <= chead_q;
      chit_q     <= cpush_ok && (ctail_q == chead_q);
      pos_q      <= pos_d;
      if (ctrl_i.idle_set) begin
        idle_q <= 1'b1;
      end else if (ctrl_i.idle_clr) begin
        idle_q <= 1'b0;
      end
      if (ctrl_i.multi_set) begin
        multi_q <= 1'b1;
      end else if (ctrl_i.multi_clr) begin
        multi_q <= 1'b0;
      end
      if (ctrl_i.wmode_set) begin
        wmode_q <= ctrl_i.wmode_val;
      end else if (ctrl_i.wmode_clr) begin
        wmode_q <= WM_OFF;
      end
      if (ctrl_i.pwr_ff || ctrl_i.resp_pop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      mosi_q <= mosi_byte_i;
    end
    if (ctrl_i.cap_first) begin
      idx_q <= cdata_q[5:0];
    end
    if (ctrl_i.cap_arg) begin
      arg_q <= {arg_q[23:0], cdata_q};
    end
    if (ctrl_i.img_rd) begin
      inr_q <= inr;
    end
    if (ctrl_i.pwr_ff) begin
      out_byte_q <= BYTE_FF;
    end else if (ctrl_i.resp_pop) begin
      out_byte_q <= rempty ? BYTE_FF : rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rpush_ok) begin
      resp_mem[rtail_q] <= push_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= resp_mem[rhead_q];
  end

  always_ff @(posedge clk_i) begin
    if (cpush_ok) begin
      cmd_mem[ctail_q] <= mosi_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cdata_q <= cmd_mem[chead_q];
  end

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      img_mem[pos_q[CARD_ADDR_BITS-1:0]] <= img_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    img_rdata_q <= img_mem[pos_q[CARD_ADDR_BITS-1:0]];
  end

  always_comb begin
    stat_o.cmd_empty    = (ccount_q == '0);
    stat_o.cmd_ge6      = (ccount_q >= CCW'(6));
    stat_o.cmd_ge_frame = (ccount_q >= CCW'(FRAME_BYTES));
    stat_o.cmd_ok       = (crd_addr_q == chead_q) && !chit_q;
    stat_o.cmd_head     = cdata_q;
    stat_o.resp_empty   = rempty;
    stat_o.resp_ok      = (rrd_addr_q == rhead_q) && !rhit_q;
    stat_o.resp_head_ff = rempty || (rdata_q == BYTE_FF);
    stat_o.wmode        = wmode_q;
    stat_o.multi        = multi_q;
    stat_o.idx          = idx_q;
    stat_o.clr_done     = pos_q[CARD_ADDR_BITS];
    stat_o.mosi_hi      = mosi_q[7];
    stat_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign miso_byte_o = out_byte_q;

endmodule

// ----- rtl/sdspi_ctrl.sv -----
module sdspi_ctrl #(
  parameter int unsigned READ_GAP_BYTES  = 4,
  parameter int unsigned STOP_BUSY_BYTES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              card_powered_i,
  input  sdspi_pkg::stat_t  stat_i,
  output logic              in_stall_o,
  output sdspi_pkg::ctrl_t  ctrl_o
);
  import sdspi_pkg::*;

  localparam int unsigned CNT_W =
      $clog2(BLOCK_BYTES + READ_GAP_BYTES + STOP_BUSY_BYTES + 4);
  localparam int unsigned STOP_LEN = STOP_BUSY_BYTES + 4;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc;
  logic [7:0]       want;

  assign acc  = (state_q == ST_IDLE) && in_valid_i && stat_i.out_free;
  assign want = (stat_i.wmode == WM_SINGLE) ? TOKEN_SINGLE : TOKEN_MULTI;
  assign in_stall_o = !((state_q == ST_IDLE) && stat_i.out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_CLEAR: if (stat_i.clr_done) state_d = ST_IDLE;
      ST_IDLE:  if (acc && card_powered_i) state_d = ST_PUSH;
      ST_PUSH:  state_d = ST_POP;
      ST_POP: begin
        if (stat_i.resp_empty || stat_i.resp_ok) begin
          if (stat_i.wmode != WM_OFF) begin
            state_d = stat_i.resp_head_ff ? ST_WSKIP : ST_IDLE;
          end else begin
            state_d = ST_MR;
          end
        end
      end
      ST_WSKIP: begin
        if (stat_i.cmd_empty) begin
          state_d = ST_IDLE;
        end else if (stat_i.cmd_ok && stat_i.cmd_head != BYTE_FF) begin
          if (stat_i.cmd_head != want || !stat_i.cmd_ge_frame) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_WDATA;
            cnt_d   = '0;
          end
        end
      end
      ST_WDATA: begin
        if (stat_i.cmd_ok) begin
          if (cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
            state_d = ST_WCRC;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_WCRC: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_WEND;
        cnt_d = cnt_q + 1'b1;
      end
      ST_WEND: state_d = ST_MR;
      ST_MR: begin
        state_d = (stat_i.multi && stat_i.resp_empty) ? ST_BTOK : ST_LOOP;
        cnt_d   = '0;
      end
      ST_LOOP: state_d = stat_i.cmd_ge6 ? ST_SKIP : ST_IDLE;
      ST_SKIP: begin
        if (stat_i.cmd_empty) begin
          state_d = ST_IDLE;
        end else if (stat_i.cmd_ok && !stat_i.cmd_head[7]) begin
          state_d = stat_i.cmd_ge6 ? ST_CAP : ST_IDLE;
          cnt_d   = '0;
        end
      end
      ST_CAP: begin
        if (stat_i.cmd_ok) begin
          if (cnt_q == CNT_W'(5)) begin
            state_d = ST_EXEC;
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EXEC: begin
        cnt_d = '0;
        unique case (stat_i.idx) inside
          CMD_SEND_IF_COND: state_d = ST_R8;
          CMD_STOP_TRAN:    state_d = ST_STOP;
          CMD_READ_SINGLE, CMD_READ_MULTI:
            state_d = (READ_GAP_BYTES > 1) ? ST_GAP : ST_BTOK;
          default:          state_d = ST_LOOP;
        endcase
      end
      ST_R8: begin
        if (cnt_q == CNT_W'(3)) state_d = ST_LOOP;
        cnt_d = cnt_q + 1'b1;
      end
      ST_STOP: begin
        if (cnt_q == CNT_W'(STOP_LEN - 1)) state_d = ST_LOOP;
        cnt_d = cnt_q + 1'b1;
      end
      ST_GAP: begin
        if (cnt_q == CNT_W'(READ_GAP_BYTES - 2)) begin
          state_d = ST_BTOK;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_BTOK: begin
        state_d = ST_BRD;
        cnt_d   = '0;
      end
      ST_BRD: state_d = ST_BPUSH;
      ST_BPUSH: begin
        if (cnt_q == CNT_W'(BLOCK_BYTES - 1)) begin
          state_d = ST_BCRC;
          cnt_d   = '0;
        end else begin
          state_d = ST_BRD;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_BCRC: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_LOOP;
        cnt_d = cnt_q + 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.push_sel = PB_FF;
    ctrl_o.wmode_val = WM_OFF;
    unique case (state_q)
      ST_CLEAR: begin
        ctrl_o.clr_step = !stat_i.clr_done;
        ctrl_o.pos_zero = stat_i.clr_done;
      end
      ST_IDLE: begin
        ctrl_o.accept = acc;
        ctrl_o.pwr_ff = acc && !card_powered_i;
      end
      ST_PUSH: begin
        ctrl_o.cmd_push = !stat_i.cmd_empty || (stat_i.wmode != WM_OFF) || !stat_i.mosi_hi;
      end
      ST_POP: ctrl_o.resp_pop = stat_i.resp_empty || stat_i.resp_ok;
      ST_WSKIP: begin
        if (!stat_i.cmd_empty && stat_i.cmd_ok) begin
          if (stat_i.cmd_head == BYTE_FF) begin
            ctrl_o.cmd_pop = 1'b1;
          end else if (stat_i.cmd_head != want) begin
            // any other token ends write mode and is dropped
            ctrl_o.cmd_pop   = 1'b1;
            ctrl_o.wmode_clr = 1'b1;
          end else if (stat_i.cmd_ge_frame) begin
            ctrl_o.cmd_pop = 1'b1;
          end
        end
      end
      ST_WDATA: begin
        ctrl_o.img_wr  = stat_i.cmd_ok;
        ctrl_o.cmd_pop = stat_i.cmd_ok;
      end
      ST_WCRC: ctrl_o.cmd_pop = 1'b1;
      ST_WEND: begin
        ctrl_o.resp_push = 1'b1;
        ctrl_o.push_sel  = PB_E5;
        ctrl_o.wmode_clr = (stat_i.wmode == WM_SINGLE);
      end
      ST_SKIP: begin
        ctrl_o.cmd_pop = !stat_i.cmd_empty && stat_i.cmd_ok && stat_i.cmd_head[7];
      end
      ST_CAP: begin
        ctrl_o.cmd_pop   = stat_i.cmd_ok;
        ctrl_o.cap_first = stat_i.cmd_ok && (cnt_q == '0);
        ctrl_o.cap_arg   = stat_i.cmd_ok && (cnt_q != '0) && (cnt_q != CNT_W'(5));
      end
      ST_EXEC: begin
        ctrl_o.resp_push = 1'b1;
        unique case (stat_i.idx) inside
          CMD_GO_IDLE: begin
            ctrl_o.idle_set = 1'b1;
            ctrl_o.push_sel = PB_01;
          end
          CMD_SEND_OP_COND: begin
            ctrl_o.idle_clr = 1'b1;
            ctrl_o.push_sel = PB_00;
          end
          CMD_SEND_IF_COND: ctrl_o.push_sel = PB_R1;
          CMD_STOP_TRAN: begin
            ctrl_o.resp_push  = 1'b0;
            ctrl_o.resp_clear = 1'b1;
            ctrl_o.multi_clr  = 1'b1;
          end
          CMD_SET_BLOCKLEN: ctrl_o.push_sel = PB_R1_LEN;
          CMD_READ_SINGLE, CMD_READ_MULTI: begin
            ctrl_o.push_sel  = PB_R1;
            ctrl_o.pos_load  = 1'b1;
            ctrl_o.multi_set = (stat_i.idx == CMD_READ_MULTI);
          end
          CMD_WRITE_SINGLE, CMD_WRITE_MULTI: begin
            ctrl_o.push_sel  = PB_R1;
            ctrl_o.pos_load  = 1'b1;
            ctrl_o.wmode_set = 1'b1;
            ctrl_o.wmode_val = (stat_i.idx == CMD_WRITE_MULTI) ? WM_MULTI : WM_SINGLE;
          end
          default: ctrl_o.push_sel = PB_R1_ILL;
        endcase
      end
      ST_R8: begin
        ctrl_o.resp_push = 1'b1;
        if (cnt_q == CNT_W'(2)) begin
          ctrl_o.push_sel = PB_01;
        end else if (cnt_q == CNT_W'(3)) begin
          ctrl_o.push_sel = PB_ARG;
        end else begin
          ctrl_o.push_sel = PB_00;
        end
      end
      ST_STOP: begin
        ctrl_o.resp_push = 1'b1;
        ctrl_o.push_sel  = (cnt_q < CNT_W'(2) || cnt_q == CNT_W'(STOP_LEN - 1)) ?
                           PB_FF : PB_00;
      end
      ST_GAP: ctrl_o.resp_push = 1'b1;
      ST_BTOK: begin
        ctrl_o.resp_push = 1'b1;
        ctrl_o.push_sel  = PB_FE;
      end
      ST_BRD: ctrl_o.img_rd = 1'b1;
      ST_BPUSH: begin
        ctrl_o.resp_push = 1'b1;
        ctrl_o.push_sel  = PB_IMG;
      end
      ST_BCRC: ctrl_o.resp_push = 1'b1;
      default: ;
    endcase
  end

endmodule
